// ===== rtl/core/gif_lzw_encoder_macros.svh =====
// assertion macros for the gif lzw encoder
`ifndef GIF_LZW_ENCODER_MACROS_SVH
`define GIF_LZW_ENCODER_MACROS_SVH
`ifndef SYNTHESIS
`define GLE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("gle check failed");
`define GLE_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error("gle check failed");
`else
`define GLE_ASSERT(lbl, clk, rstn, prop)
`define GLE_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ===== rtl/core/gle_pkg.sv =====
// shared types, constants and helpers of the gif lzw encoder
package gle_pkg;

  localparam int TableDepth   = 8192;
  localparam int MaxCodeBits  = 12;
  localparam int CodeW        = 12;
  localparam int KeyW         = 20;
  localparam int EpochW       = 6;
  localparam int FullCode     = 4095;
  localparam int OpQueueDepth = 4;
  localparam int OutQueueDepth = 4;
  localparam logic [3:0] ColorResRst = 4'd8;
  localparam logic [31:0] PixelCountRst = 32'd1;

  typedef enum logic [1:0] {
    RegColorRes   = 2'd0,
    RegPixelCount = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] pix;
    logic       surplus;
    logic       first;
    logic       final_px;
  } op_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       too_many;
  } res_t;

  typedef struct packed {
    logic [EpochW-1:0] epoch;
    logic [KeyW-1:0]   key;
    logic [CodeW-1:0]  code;
  } entry_t;

  function automatic logic [3:0] eff_res(logic [3:0] res);
    logic [3:0] r;
    r = res;
    if (res < 4'd2) r = 4'd2;
    if (res > 4'd8) r = 4'd8;
    return r;
  endfunction

  function automatic logic [KeyW-1:0] key_hash(logic [KeyW-1:0] k);
    return k ^ (k >> CodeW);
  endfunction

endpackage

// ===== rtl/core/gle_ram.sv =====
// generic simple dual port ram with registered read
module gle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

// ===== rtl/core/gle_fifo.sv =====
// small register queue between encoder stages
module gle_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slots_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + PW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + PW'(1) : rd_q;
    cnt_d = cnt_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_q] <= data_i;
    end
  end
endmodule

// ===== rtl/core/gle_front.sv =====
// front end: takes pixels, masks them and tags first, final and surplus
module gle_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              restart_i,
  input  logic [31:0]       pix_count_i,
  input  logic [3:0]        color_res_i,
  input  logic              push_i,
  input  logic [7:0]        pixel_i,
  output logic              full_o,
  output logic              busy_o,
  output logic              op_push_o,
  output gle_pkg::op_t      op_o,
  input  logic              op_full_i
);
  import gle_pkg::*;

  logic [31:0] left_q, left_d;
  logic        started_q, started_d;
  logic [7:0]  one_sh, mask;
  logic        take;

  assign one_sh    = 8'(1) << eff_res(color_res_i);
  assign mask      = one_sh - 8'd1;
  assign full_o    = op_full_i;
  assign take      = push_i && !op_full_i;
  assign op_push_o = take;
  assign busy_o    = started_q && (left_q != '0);

  always_comb begin
    left_d      = left_q;
    started_d   = started_q;
    op_o.pix      = pixel_i & mask;
    op_o.surplus  = (left_q == '0);
    op_o.first    = !started_q;
    op_o.final_px = (left_q == 32'd1);
    if (take && (left_q != '0)) begin
      left_d    = left_q - 32'd1;
      started_d = 1'b1;
    end
    if (restart_i) begin
      left_d    = pix_count_i;
      started_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q    <= PixelCountRst;
      started_q <= 1'b0;
    end else begin
      left_q    <= left_d;
      started_q <= started_d;
    end
  end
endmodule

// ===== rtl/core/gle_back.sv =====
// back end: dictionary probe, code emission and lsb first byte packing
`include "gif_lzw_encoder_macros.svh"
module gle_back #(
  parameter int TABLE_DEPTH = gle_pkg::TableDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          restart_i,
  input  logic [3:0]    color_res_i,
  input  logic          op_valid_i,
  input  gle_pkg::op_t  op_i,
  output logic          op_pop_o,
  output logic          res_push_o,
  output gle_pkg::res_t res_o,
  input  logic          res_full_i
);
  import gle_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  typedef enum logic [13:0] {
    S_CLEAR = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_FIRST = 14'b00000000000100,
    S_DICT  = 14'b00000000001000,
    S_LOOK  = 14'b00000000010000,
    S_CMP   = 14'b00000000100000,
    S_MISS  = 14'b00000001000000,
    S_RESET = 14'b00000010000000,
    S_FINAL = 14'b00000100000000,
    S_EOI   = 14'b00001000000000,
    S_FLUSH = 14'b00010000000000,
    S_EMIT  = 14'b00100000000000,
    S_DRAIN = 14'b01000000000000,
    S_SURP  = 14'b10000000000000
  } state_e;

  state_e            state_q, state_d, ret_q, ret_d;
  op_t               op_q, op_d;
  logic [CodeW-1:0]  prefix_q, prefix_d, nfc_q, nfc_d, code_q, code_d;
  logic              have_q, have_d, eoi_q, eoi_d;
  logic [3:0]        cw_q, cw_d, res;
  logic [23:0]       acc_q, acc_d;
  logic [4:0]        cnt_q, cnt_d;
  logic [KeyW-1:0]   key_q, key_d, key_new, key_hs;
  logic [AW-1:0]     slot_q, slot_d;
  logic [EpochW-1:0] epoch_q, epoch_d;
  logic [CodeW-1:0]  clr_code, pix_code;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  entry_t            ram_wdata, rd;
  logic              res_push;
  res_t              res_d;

  assign res      = eff_res(color_res_i);
  assign clr_code = CodeW'(1) << res;
  assign pix_code = CodeW'(op_q.pix);
  assign key_new  = {prefix_q, op_q.pix};
  assign key_hs   = key_hash(key_new);

  gle_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_dict (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rd)
  );

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    op_d      = op_q;
    prefix_d  = prefix_q;
    nfc_d     = nfc_q;
    code_d    = code_q;
    have_d    = have_q;
    eoi_d     = eoi_q;
    cw_d      = cw_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    key_d     = key_q;
    slot_d    = slot_q;
    epoch_d   = epoch_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = slot_q;
    ram_raddr = slot_q;
    ram_wdata = '0;
    op_pop_o  = 1'b0;
    res_push  = 1'b0;
    res_d     = '0;
    case (state_q)
      S_CLEAR: begin
        ram_we  = 1'b1;
        nfc_d   = clr_code + CodeW'(2);
        cw_d    = res + 4'd1;
        epoch_d = EpochW'(1);
        slot_d  = slot_q + AW'(1);
        if (slot_q == '1) begin
          state_d = ret_q;
        end
      end
      S_IDLE: begin
        if (op_valid_i) begin
          op_pop_o = 1'b1;
          op_d     = op_i;
          state_d  = op_i.surplus ? S_SURP : S_FIRST;
        end
      end
      S_SURP: begin
        if (!res_full_i) begin
          res_push       = 1'b1;
          res_d.too_many = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_FIRST: begin
        if (op_q.first) begin
          code_d  = clr_code;
          ret_d   = S_DICT;
          state_d = S_EMIT;
        end else begin
          state_d = S_DICT;
        end
      end
      S_DICT: begin
        if (!have_q) begin
          prefix_d = pix_code;
          have_d   = 1'b1;
          state_d  = S_FINAL;
        end else begin
          key_d   = key_new;
          slot_d  = key_hs[AW-1:0];
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        ram_re  = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (rd.epoch != epoch_q) begin
          code_d  = prefix_q;
          ret_d   = S_MISS;
          state_d = S_EMIT;
        end else if (rd.key == key_q) begin
          prefix_d = rd.code;
          state_d  = S_FINAL;
        end else begin
          slot_d  = slot_q + AW'(1);
          state_d = S_LOOK;
        end
      end
      S_MISS: begin
        prefix_d = pix_code;
        if (nfc_q >= CodeW'(FullCode)) begin
          code_d  = clr_code;
          ret_d   = S_RESET;
          state_d = S_EMIT;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = '{epoch: epoch_q, key: key_q, code: nfc_q};
          nfc_d     = nfc_q + CodeW'(1);
          state_d   = S_FINAL;
        end
      end
      S_RESET: begin
        nfc_d = clr_code + CodeW'(2);
        cw_d  = res + 4'd1;
        if (epoch_q == '1) begin
          slot_d  = '0;
          ret_d   = S_FINAL;
          state_d = S_CLEAR;
        end else begin
          epoch_d = epoch_q + EpochW'(1);
          state_d = S_FINAL;
        end
      end
      S_FINAL: begin
        if (op_q.final_px) begin
          code_d  = prefix_q;
          ret_d   = S_EOI;
          state_d = S_EMIT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EOI: begin
        code_d  = clr_code + CodeW'(1);
        eoi_d   = 1'b1;
        ret_d   = S_FLUSH;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        acc_d   = acc_q | (24'(code_q) << cnt_q);
        cnt_d   = cnt_q + 5'(cw_q);
        state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (cnt_q >= 5'd8) begin
          if (!res_full_i) begin
            res_push       = 1'b1;
            res_d.out_byte = acc_q[7:0];
            res_d.last     = eoi_q && (cnt_q == 5'd8);
            acc_d          = acc_q >> 8;
            cnt_d          = cnt_q - 5'd8;
          end
        end else begin
          if (({1'b0, nfc_q} >= (13'(1) << cw_q)) && (cw_q < 4'(MaxCodeBits))) begin
            cw_d = cw_q + 4'd1;
          end
          state_d = ret_q;
        end
      end
      S_FLUSH: begin
        if (cnt_q != '0) begin
          if (!res_full_i) begin
            res_push       = 1'b1;
            res_d.out_byte = acc_q[7:0];
            res_d.last     = (cnt_q <= 5'd8);
            acc_d          = acc_q >> 8;
            cnt_d          = (cnt_q >= 5'd8) ? cnt_q - 5'd8 : 5'd0;
          end
        end else begin
          acc_d   = '0;
          eoi_d   = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
        slot_d  = '0;
        ret_d   = S_IDLE;
      end
    endcase
    if (restart_i) begin
      state_d  = S_CLEAR;
      slot_d   = '0;
      ret_d    = S_IDLE;
      prefix_d = '0;
      have_d   = 1'b0;
      acc_d    = '0;
      cnt_d    = '0;
      eoi_d    = 1'b0;
    end
  end

  assign res_push_o = res_push;
  assign res_o      = res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      ret_q    <= S_IDLE;
      prefix_q <= '0;
      nfc_q    <= '0;
      have_q   <= 1'b0;
      eoi_q    <= 1'b0;
      cw_q     <= '0;
      acc_q    <= '0;
      cnt_q    <= '0;
      slot_q   <= '0;
      epoch_q  <= '0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      prefix_q <= prefix_d;
      nfc_q    <= nfc_d;
      have_q   <= have_d;
      eoi_q    <= eoi_d;
      cw_q     <= cw_d;
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      slot_q   <= slot_d;
      epoch_q  <= epoch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    code_q <= code_d;
    key_q  <= key_d;
  end

  `GLE_ASSERT(a_idle_cnt, clk_i, rst_ni, (state_q == S_IDLE) |-> (cnt_q < 5'd8))
  `GLE_NEVER(a_push_full, clk_i, rst_ni, res_push && res_full_i)
  `GLE_ASSERT(a_epoch_live, clk_i, rst_ni, (state_q != S_CLEAR) |-> (epoch_q != '0))
  `GLE_ASSERT(a_cw_max, clk_i, rst_ni, (state_q == S_IDLE) |-> (cw_q <= 4'(MaxCodeBits)))
endmodule

// ===== rtl/core/gif_lzw_encoder.sv =====
// top level of the gif lzw encoder
//
//  channel   direction  handshake            payload
//  pixels    in         push / full          pixel_i
//  codes     out        empty / pop          out_byte_o, last_o, too_many_o
//  config    in         cfg_we_i             cfg_idx_i, cfg_wdata_i
//
// a matched pixel passes control states and a look and compare per dictionary
// probe; a new string adds the miss state, emit per code and drain per byte
// the dictionary is one ram port pair, probed linearly a slot at a time
// after reset and after each accepted config write the dictionary is swept slot
// by slot over all TABLE_DEPTH slots, and again on every 63rd dictionary reset;
// pixels queue up meanwhile, and a stalled pop holds the back end at the next byte
module gif_lzw_encoder #(
  parameter int TABLE_DEPTH = gle_pkg::TableDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  pixel_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic        too_many_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);
  import gle_pkg::*;

  logic [3:0]  color_res_q;
  logic [31:0] pixel_count_q, pc_next;
  logic        busy, cfg_ok;
  logic        op_push, op_full, op_empty, op_pop, res_push, res_full;
  op_t         op_in, op_head;
  logic [$bits(op_t)-1:0]  opq_data;
  logic [$bits(res_t)-1:0] outq_data;
  res_t        res_in, res_head;

  assign cfg_ok  = cfg_we_i && !busy &&
                   ((cfg_idx_i == RegColorRes) || (cfg_idx_i == RegPixelCount));
  assign pc_next = (cfg_idx_i == RegPixelCount) ? cfg_wdata_i : pixel_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_res_q   <= ColorResRst;
      pixel_count_q <= PixelCountRst;
    end else if (cfg_ok) begin
      if (cfg_idx_i == RegColorRes) begin
        color_res_q <= cfg_wdata_i[3:0];
      end
      pixel_count_q <= pc_next;
    end
  end

  gle_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (cfg_ok),
    .pix_count_i(pc_next),
    .color_res_i(color_res_q),
    .push_i     (push),
    .pixel_i    (pixel_i),
    .full_o     (full),
    .busy_o     (busy),
    .op_push_o  (op_push),
    .op_o       (op_in),
    .op_full_i  (op_full)
  );

  gle_fifo #(
    .WIDTH($bits(op_t)),
    .DEPTH(OpQueueDepth)
  ) u_op_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (op_push),
    .data_i (op_in),
    .full_o (op_full),
    .pop_i  (op_pop),
    .data_o (opq_data),
    .empty_o(op_empty)
  );

  assign op_head = op_t'(opq_data);

  gle_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (cfg_ok),
    .color_res_i(color_res_q),
    .op_valid_i (!op_empty),
    .op_i       (op_head),
    .op_pop_o   (op_pop),
    .res_push_o (res_push),
    .res_o      (res_in),
    .res_full_i (res_full)
  );

  gle_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(OutQueueDepth)
  ) u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (outq_data),
    .empty_o(empty)
  );

  assign res_head   = res_t'(outq_data);
  assign out_byte_o = res_head.out_byte;
  assign last_o     = res_head.last;
  assign too_many_o = res_head.too_many;
endmodule
